FILE: design/read_range_page_splitter_defines.svh
// Assertion macros used by the checker file.
`ifndef READ_RANGE_PAGE_SPLITTER_DEFINES_SVH
`define READ_RANGE_PAGE_SPLITTER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define RRPS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define RRPS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/rrps_pkg.sv
package rrps_pkg;

	// stream widths; the tdata widths are whole bytes
	localparam int IN_TDATA_W  = 160;
	localparam int OUT_TDATA_W = 72;
	localparam int STATUS_W    = 2;

	localparam int OBJ_W      = 63;
	localparam int REQ_W      = 32;
	localparam int LEN_W      = 20;
	localparam int SEQ_W      = 32;
	localparam int OFF_W      = 19;
	localparam int PLANNED_W  = 33;
	localparam int PLOG_W     = 5;
	localparam int CFG_ADDR_W = 2;
	localparam int CFG_DATA_W = 32;

	localparam logic [PLOG_W-1:0] PAGE_LOG2_MIN   = 5'd12;
	localparam logic [PLOG_W-1:0] PAGE_LOG2_MAX   = 5'd19;
	localparam logic [PLOG_W-1:0] PAGE_LOG2_RESET = 5'd18;
	localparam logic [REQ_W-1:0]  MIN_LEN_RESET   = 32'd524288;
	localparam logic [REQ_W-1:0]  MAX_LEN_RESET   = 32'd134217728;

	// register indexes
	localparam logic [CFG_ADDR_W-1:0] REG_PAGE_LOG2    = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_MIN_READ_LEN = 2'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_MAX_READ_LEN = 2'd2;

	// result status codes
	localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_TRUNC = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_ERR   = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_BOUND,
		ST_LEN,
		ST_EMIT
	} state_t;

endpackage

FILE: design/read_range_page_splitter.sv
// Read range page splitter. Takes one read request (object length, start
// offset, requested length) and returns its page pieces in order, each with
// page number, offset within the page and length; tlast marks the final
// piece and tuser carries the status (ok, truncated at the piece limit, or
// offset at or past the end, the last as one empty item); a request whose
// read cap or needed length is zero returns no item. The block checks the
// offset against the object end, then bounds the amount to read (at most
// MAX_PIECES pieces), then for each piece sizes it and loads it into the
// output register, advancing cursor and byte count; each load waits while
// the output is held by tready, the empty item for an offset at or past the
// end too. s_tready is high only while no request is in hand, so the next
// request is taken in the idle cycle after the last piece is loaded.
// Write configuration only while the block is idle.
module read_range_page_splitter #(
	parameter int MAX_PIECES = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// object_len[62:0], start_offset[125:63], request_len[157:126]
	input  logic [rrps_pkg::IN_TDATA_W-1:0]     s_tdata,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// piece_len[19:0], page_sequence[51:20], offset_in_page[70:52]
	output logic [rrps_pkg::OUT_TDATA_W-1:0]    m_tdata,
	output logic                                m_tlast,
	// status[1:0]
	output logic [rrps_pkg::STATUS_W-1:0]       m_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	input  logic                                cfg_we,
	input  logic [rrps_pkg::CFG_ADDR_W-1:0]     cfg_addr,
	input  logic [rrps_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

	localparam int CNT_W = $clog2(MAX_PIECES + 1);

	// configuration
	logic [rrps_pkg::PLOG_W-1:0]     page_log2_q;
	logic [rrps_pkg::REQ_W-1:0]      min_len_q;
	logic [rrps_pkg::REQ_W-1:0]      max_len_q;

	rrps_pkg::state_t                state_q, state_d;

	// request working set
	logic [rrps_pkg::OBJ_W-1:0]      obj_q;
	logic [rrps_pkg::OBJ_W-1:0]      cursor_q;
	logic [rrps_pkg::OBJ_W-1:0]      rem_q;
	logic [rrps_pkg::REQ_W-1:0]      req_q;
	logic [rrps_pkg::REQ_W-1:0]      cap_q;
	logic [rrps_pkg::REQ_W-1:0]      need_q;
	logic [rrps_pkg::PLANNED_W-1:0]  planned_q;
	logic [CNT_W-1:0]                count_q;
	logic [rrps_pkg::LEN_W-1:0]      len_q;
	logic [rrps_pkg::OFF_W-1:0]      off_q;
	logic [rrps_pkg::SEQ_W-1:0]      seq_q;

	// output register
	logic                            out_valid_q;
	logic [rrps_pkg::LEN_W-1:0]      out_len_q;
	logic [rrps_pkg::SEQ_W-1:0]      out_seq_q;
	logic [rrps_pkg::OFF_W-1:0]      out_off_q;
	logic                            out_last_q;
	logic [rrps_pkg::STATUS_W-1:0]   out_status_q;

	// combinational
	logic                            out_free;
	logic                            out_load;
	logic                            load_err;
	logic                            in_accept;
	logic [rrps_pkg::OBJ_W:0]        diff;
	logic                            past_end;
	logic [rrps_pkg::REQ_W-1:0]      cap_d;
	logic [rrps_pkg::REQ_W-1:0]      need_d;
	logic [rrps_pkg::PLOG_W-1:0]     pl_eff;
	logic [rrps_pkg::LEN_W-1:0]      psize;
	logic [rrps_pkg::OFF_W-1:0]      page_mask;
	logic [rrps_pkg::OFF_W-1:0]      off_d;
	logic [rrps_pkg::LEN_W-1:0]      span;
	logic [rrps_pkg::LEN_W-1:0]      len_d;
	logic [rrps_pkg::PLANNED_W-1:0]  planned_n;
	logic [CNT_W-1:0]                count_n;
	logic                            cont;
	logic                            trunc;
	logic                            piece_last;

	assign in_accept = s_tvalid && s_tready;
	assign s_tready  = (state_q == rrps_pkg::ST_IDLE);
	assign out_free  = !out_valid_q || m_tready;

	// clamp page size into the supported range
	always_comb begin
		if (page_log2_q < rrps_pkg::PAGE_LOG2_MIN) begin
			pl_eff = rrps_pkg::PAGE_LOG2_MIN;
		end else if (page_log2_q > rrps_pkg::PAGE_LOG2_MAX) begin
			pl_eff = rrps_pkg::PAGE_LOG2_MAX;
		end else begin
			pl_eff = page_log2_q;
		end
	end

	assign psize     = rrps_pkg::LEN_W'(1) << pl_eff;
	assign page_mask = rrps_pkg::OFF_W'(psize - rrps_pkg::LEN_W'(1));

	// setup: bytes left, then cap and need
	assign diff     = {1'b0, obj_q} - {1'b0, cursor_q};
	assign past_end = diff[rrps_pkg::OBJ_W] || (diff[rrps_pkg::OBJ_W-1:0] == '0);
	assign cap_d    = (rem_q < {31'b0, max_len_q}) ? rem_q[rrps_pkg::REQ_W-1:0] : max_len_q;
	assign need_d   = (req_q <= min_len_q) ? min_len_q : req_q;

	// piece size: cut at page end and object end
	assign off_d = cursor_q[rrps_pkg::OFF_W-1:0] & page_mask;
	assign span  = psize - {1'b0, off_d};
	assign len_d = (rem_q < {43'b0, span}) ? rem_q[rrps_pkg::LEN_W-1:0] : span;

	// advance: decide whether another piece follows
	assign planned_n  = planned_q + {13'b0, len_q};
	assign count_n    = count_q + CNT_W'(1);
	assign cont       = (planned_n < {1'b0, need_q}) && (planned_n < {1'b0, cap_q});
	assign trunc      = cont && (count_n == CNT_W'(MAX_PIECES));
	assign piece_last = !cont || trunc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rrps_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		out_load = 1'b0;
		load_err = 1'b0;
		unique case (state_q)
			rrps_pkg::ST_IDLE: begin
				if (in_accept) begin
					state_d = rrps_pkg::ST_CHECK;
				end
			end
			rrps_pkg::ST_CHECK: begin
				if (!past_end) begin
					state_d = rrps_pkg::ST_BOUND;
				end else if (out_free) begin
					out_load = 1'b1;
					load_err = 1'b1;
					state_d  = rrps_pkg::ST_IDLE;
				end
			end
			rrps_pkg::ST_BOUND: begin
				// nothing to read when cap or need is zero
				if (cap_d == '0 || need_d == '0) begin
					state_d = rrps_pkg::ST_IDLE;
				end else begin
					state_d = rrps_pkg::ST_LEN;
				end
			end
			rrps_pkg::ST_LEN: begin
				state_d = rrps_pkg::ST_EMIT;
			end
			rrps_pkg::ST_EMIT: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = piece_last ? rrps_pkg::ST_IDLE : rrps_pkg::ST_LEN;
				end
			end
		endcase
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			rrps_pkg::ST_IDLE: begin
				if (in_accept) begin
					obj_q    <= s_tdata[62:0];
					cursor_q <= s_tdata[125:63];
					req_q    <= s_tdata[157:126];
				end
			end
			rrps_pkg::ST_CHECK: begin
				rem_q <= diff[rrps_pkg::OBJ_W-1:0];
			end
			rrps_pkg::ST_BOUND: begin
				cap_q     <= cap_d;
				need_q    <= need_d;
				planned_q <= '0;
				count_q   <= '0;
			end
			rrps_pkg::ST_LEN: begin
				len_q <= len_d;
				off_q <= off_d;
				seq_q <= rrps_pkg::SEQ_W'(cursor_q >> pl_eff);
			end
			rrps_pkg::ST_EMIT: begin
				if (out_free) begin
					cursor_q  <= cursor_q + {43'b0, len_q};
					rem_q     <= rem_q - {43'b0, len_q};
					planned_q <= planned_n;
					count_q   <= count_n;
				end
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			if (load_err) begin
				out_len_q    <= '0;
				out_seq_q    <= '0;
				out_off_q    <= '0;
				out_last_q   <= 1'b1;
				out_status_q <= rrps_pkg::STATUS_ERR;
			end else begin
				out_len_q    <= len_q;
				out_seq_q    <= seq_q;
				out_off_q    <= off_q;
				out_last_q   <= piece_last;
				out_status_q <= trunc ? rrps_pkg::STATUS_TRUNC : rrps_pkg::STATUS_OK;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_off_q, out_seq_q, out_len_q};
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_status_q;

	// configuration registers; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_log2_q <= rrps_pkg::PAGE_LOG2_RESET;
			min_len_q   <= rrps_pkg::MIN_LEN_RESET;
			max_len_q   <= rrps_pkg::MAX_LEN_RESET;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				rrps_pkg::REG_PAGE_LOG2:    page_log2_q <= cfg_wdata[rrps_pkg::PLOG_W-1:0];
				rrps_pkg::REG_MIN_READ_LEN: min_len_q   <= cfg_wdata;
				rrps_pkg::REG_MAX_READ_LEN: max_len_q   <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

endmodule

FILE: design/rrps_checker.sv
`include "read_range_page_splitter_defines.svh"

module rrps_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	input  logic                                s_tready,
	input  logic [rrps_pkg::OUT_TDATA_W-1:0]    m_tdata,
	input  logic                                m_tlast,
	input  logic [rrps_pkg::STATUS_W-1:0]       m_tuser,
	input  logic                                m_tvalid,
	input  logic                                m_tready
);

	// hold a stalled item
	`RRPS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result item changed while stalled")

	// past-end result is one empty final item
	`RRPS_ASSERT_NOW(a_err_empty, m_tvalid && (m_tuser == rrps_pkg::STATUS_ERR), m_tlast && (m_tdata == '0), "error item not empty or not last")

	// truncation is only reported on the final item
	`RRPS_ASSERT_NOW(a_trunc_last, m_tvalid && (m_tuser == rrps_pkg::STATUS_TRUNC), m_tlast, "truncated status on a non-final item")

	// a real piece always covers bytes
	`RRPS_ASSERT_NOW(a_piece_len, m_tvalid && (m_tuser != rrps_pkg::STATUS_ERR), m_tdata[19:0] != '0, "piece with zero length")

	// one request at a time
	`RRPS_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "ready held high after an accepted item")

endmodule

bind read_range_page_splitter rrps_checker u_rrps_checker (.*);

FILE: tb/tb_read_range_page_splitter.sv
module tb_read_range_page_splitter;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_PIECES = 64;
	localparam logic [rrps_pkg::CFG_ADDR_W-1:0] REG_UNUSED = 2'd3;
	localparam logic [rrps_pkg::OBJ_W-1:0] OBJ_MAX = {rrps_pkg::OBJ_W{1'b1}};
	localparam int DRAIN_CYCLES = 2 * MAX_PIECES + 8;
	localparam int SEQ_LO = rrps_pkg::LEN_W;
	localparam int OFF_LO = rrps_pkg::LEN_W + rrps_pkg::SEQ_W;

	typedef struct packed {
		logic [rrps_pkg::OBJ_W-1:0] obj;
		logic [rrps_pkg::OBJ_W-1:0] start;
		logic [rrps_pkg::REQ_W-1:0] req;
	} read_request_t;

	typedef struct packed {
		logic [rrps_pkg::LEN_W-1:0]    len;
		logic [rrps_pkg::SEQ_W-1:0]    seq;
		logic [rrps_pkg::OFF_W-1:0]    off;
		logic                          last;
		logic [rrps_pkg::STATUS_W-1:0] status;
	} page_piece_t;

	class page_piece_scoreboard;
		page_piece_t pending_pieces[$];
		logic [rrps_pkg::PLOG_W-1:0] page_log2;
		logic [rrps_pkg::REQ_W-1:0] min_len;
		logic [rrps_pkg::REQ_W-1:0] max_len;
		int errors;

		function new();
			page_log2 = rrps_pkg::PAGE_LOG2_RESET;
			min_len = rrps_pkg::MIN_LEN_RESET;
			max_len = rrps_pkg::MAX_LEN_RESET;
			errors = 0;
		endfunction

		function void write_reg(logic [rrps_pkg::CFG_ADDR_W-1:0] idx,
				logic [rrps_pkg::CFG_DATA_W-1:0] data);
			case (idx)
				rrps_pkg::REG_PAGE_LOG2:    page_log2 = data[rrps_pkg::PLOG_W-1:0];
				rrps_pkg::REG_MIN_READ_LEN: min_len = data[rrps_pkg::REQ_W-1:0];
				rrps_pkg::REG_MAX_READ_LEN: max_len = data[rrps_pkg::REQ_W-1:0];
				default: ;
			endcase
		endfunction

		// split one accepted request into the pieces the block must return
		function void note_request(read_request_t r);
			page_piece_t pieces[$];
			page_piece_t p;
			logic [63:0] obj, cursor, left, cap, need, planned, len, off, psize, shifted;
			int unsigned pl;
			obj = {1'b0, r.obj};
			cursor = {1'b0, r.start};
			if (cursor >= obj) begin
				p = '0;
				p.last = 1'b1;
				p.status = rrps_pkg::STATUS_ERR;
				pending_pieces = {pending_pieces, p};
				return;
			end
			pl = 32'((page_log2 < rrps_pkg::PAGE_LOG2_MIN) ? rrps_pkg::PAGE_LOG2_MIN :
				(page_log2 > rrps_pkg::PAGE_LOG2_MAX) ? rrps_pkg::PAGE_LOG2_MAX : page_log2);
			psize = 64'd1 << pl;
			left = obj - cursor;
			cap = ({32'd0, max_len} < left) ? {32'd0, max_len} : left;
			need = (r.req <= min_len) ? {32'd0, min_len} : {32'd0, r.req};
			planned = '0;
			while (cursor < obj && planned < need && planned < cap) begin
				if (pieces.size() >= MAX_PIECES) begin
					pieces[pieces.size()-1].status = rrps_pkg::STATUS_TRUNC;
					break;
				end
				off = cursor & (psize - 64'd1);
				len = psize - off;
				if (obj - cursor < len)
					len = obj - cursor;
				shifted = cursor >> pl;
				p.len = len[rrps_pkg::LEN_W-1:0];
				p.seq = shifted[rrps_pkg::SEQ_W-1:0];
				p.off = off[rrps_pkg::OFF_W-1:0];
				p.last = 1'b0;
				p.status = rrps_pkg::STATUS_OK;
				pieces = {pieces, p};
				cursor = cursor + len;
				planned = planned + len;
			end
			if (pieces.size() > 0)
				pieces[pieces.size()-1].last = 1'b1;
			pending_pieces = {pending_pieces, pieces};
		endfunction

		function void check_piece(page_piece_t got);
			page_piece_t want;
			if (pending_pieces.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("%0t: unexpected item len %0d seq %0h off %0h last %0b status %0d",
						$realtime, got.len, got.seq, got.off, got.last, got.status);
				return;
			end
			want = pending_pieces.pop_front();
			if (got.len != want.len || got.seq != want.seq || got.off != want.off ||
					got.last != want.last || got.status != want.status) begin
				errors++;
				if (errors <= 10) begin
					$display("%0t: mismatch, expected len %0d seq %0h off %0h last %0b status %0d",
						$realtime, want.len, want.seq, want.off, want.last, want.status);
					$display("%0t:           actual   len %0d seq %0h off %0h last %0b status %0d",
						$realtime, got.len, got.seq, got.off, got.last, got.status);
				end
			end
		endfunction

		function int pending();
			return pending_pieces.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic [rrps_pkg::IN_TDATA_W-1:0] s_tdata = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [rrps_pkg::OUT_TDATA_W-1:0] m_tdata;
	logic m_tlast;
	logic [rrps_pkg::STATUS_W-1:0] m_tuser;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic cfg_we = 1'b0;
	logic [rrps_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
	logic [rrps_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

	bit long_hold_req = 1'b0;
	page_piece_scoreboard sb;

	always #6 clk = ~clk;

	read_range_page_splitter #(
		.MAX_PIECES(MAX_PIECES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tdata(s_tdata),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.m_tuser(m_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata)
	);

	function automatic read_request_t make_request(logic [rrps_pkg::OBJ_W-1:0] obj,
			logic [rrps_pkg::OBJ_W-1:0] start, logic [rrps_pkg::REQ_W-1:0] req);
		read_request_t r;
		r.obj = obj;
		r.start = start;
		r.req = req;
		return r;
	endfunction

	function automatic logic [rrps_pkg::OBJ_W-1:0] rand_offset();
		logic [63:0] v;
		v = {$urandom, $urandom};
		return v[rrps_pkg::OBJ_W-1:0];
	endfunction

	function automatic read_request_t random_request();
		read_request_t r;
		logic [63:0] a, b, lo, hi, span;
		int kind;
		kind = $urandom_range(0, 99);
		a = {1'b0, rand_offset()};
		b = {1'b0, rand_offset()};
		lo = (a < b) ? a : b;
		hi = (a < b) ? b : a;
		if (kind < 10) begin
			// offset at or past the end
			r.obj = lo[rrps_pkg::OBJ_W-1:0];
			r.start = $urandom_range(0, 1) ? hi[rrps_pkg::OBJ_W-1:0] : lo[rrps_pkg::OBJ_W-1:0];
		end else if (kind < 40) begin
			r.obj = hi[rrps_pkg::OBJ_W-1:0];
			r.start = lo[rrps_pkg::OBJ_W-1:0];
		end else if (kind < 70) begin
			// close to the object end
			span = {32'd0, $urandom_range(1, 3 << 20)};
			r.obj = (a > span) ? a[rrps_pkg::OBJ_W-1:0] : OBJ_MAX;
			r.start = r.obj - span[rrps_pkg::OBJ_W-1:0];
		end else if (kind < 85) begin
			r.obj = {31'd0, $urandom_range(1, 1 << 22)};
			r.start = {31'd0, $urandom_range(0, 32'(r.obj - 63'd1))};
		end else begin
			// near a page boundary
			lo = a & ~((64'd1 << $urandom_range(12, 19)) - 64'd1);
			if (lo >= 64'd4)
				lo = lo - {32'd0, $urandom_range(0, 3)};
			span = {32'd0, $urandom} + 64'd1;
			hi = lo + span;
			r.start = lo[rrps_pkg::OBJ_W-1:0];
			r.obj = (hi > {1'b0, OBJ_MAX}) ? OBJ_MAX : hi[rrps_pkg::OBJ_W-1:0];
		end
		case ($urandom_range(0, 4))
			0: r.req = '0;
			1: r.req = $urandom_range(1, 1 << 20);
			2: r.req = $urandom;
			3: r.req = '1;
			default: r.req = 32'd1 << $urandom_range(0, 31);
		endcase
		return r;
	endfunction

	task automatic send_item(input read_request_t r);
		s_tdata <= {{(rrps_pkg::IN_TDATA_W - 2 * rrps_pkg::OBJ_W - rrps_pkg::REQ_W){1'b0}},
			r.req, r.start, r.obj};
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sb.note_request(r);
	endtask

	task automatic cfg_write(input logic [rrps_pkg::CFG_ADDR_W-1:0] idx,
			input logic [rrps_pkg::CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		sb.write_reg(idx, data);
	endtask

	task automatic apply_config(input logic [rrps_pkg::PLOG_W-1:0] plog,
			input logic [rrps_pkg::REQ_W-1:0] min_len,
			input logic [rrps_pkg::REQ_W-1:0] max_len);
		cfg_write(rrps_pkg::REG_PAGE_LOG2,
			{{(rrps_pkg::CFG_DATA_W - rrps_pkg::PLOG_W){1'b0}}, plog});
		cfg_write(rrps_pkg::REG_MIN_READ_LEN, min_len);
		cfg_write(rrps_pkg::REG_MAX_READ_LEN, max_len);
		cfg_we <= 1'b0;
	endtask

	// wait for every piece, then long enough for a request that yields none
	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic random_config();
		logic [rrps_pkg::PLOG_W-1:0] plog;
		logic [rrps_pkg::REQ_W-1:0] min_len, max_len;
		plog = ($urandom_range(0, 9) == 0) ? rrps_pkg::PLOG_W'($urandom_range(0, 31)) :
			rrps_pkg::PLOG_W'($urandom_range(12, 19));
		case ($urandom_range(0, 4))
			0: min_len = '0;
			1: min_len = $urandom_range(1, 1 << 20);
			2: min_len = $urandom;
			3: min_len = '1;
			default: min_len = $urandom_range(0, 1 << 23);
		endcase
		case ($urandom_range(0, 4))
			0: max_len = 32'd1;
			1: max_len = $urandom_range(1, 1 << 21);
			2: max_len = $urandom;
			3: max_len = '1;
			default: max_len = $urandom_range(1 << 19, 1 << 24);
		endcase
		apply_config(plog, min_len, max_len);
	endtask

	task automatic send_random(input int count);
		int burst_left;
		int gap;
		burst_left = $urandom_range(1, 12);
		for (int i = 0; i < count; i++) begin
			send_item(random_request());
			burst_left--;
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 12);
				s_tvalid <= 1'b0;
				if ($urandom_range(0, 29) == 0) begin
					// hold the sender until the block has emptied
					while (sb.pending() != 0)
						@(posedge clk);
					@(posedge clk);
				end else begin
					gap = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 200) :
						$urandom_range(1, 20);
					repeat (gap) @(posedge clk);
				end
			end
		end
	endtask

	initial begin
		int seg_left;
		int mode;
		int hold_left;
		bit hold_done;
		page_piece_t got;
		seg_left = 0;
		mode = 0;
		hold_left = 0;
		hold_done = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready) begin
				got.len = m_tdata[rrps_pkg::LEN_W-1:0];
				got.seq = m_tdata[OFF_LO-1:SEQ_LO];
				got.off = m_tdata[OFF_LO+rrps_pkg::OFF_W-1:OFF_LO];
				got.last = m_tlast;
				got.status = m_tuser;
				sb.check_piece(got);
			end
			if (long_hold_req && !hold_done) begin
				hold_done = 1'b1;
				hold_left = 400;
			end
			if (seg_left == 0) begin
				mode = $urandom_range(0, 3);
				seg_left = $urandom_range(20, 300);
			end
			seg_left--;
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				case (mode)
					0: m_tready <= 1'b1;
					1: m_tready <= ($urandom_range(0, 3) != 0);
					2: m_tready <= ($urandom_range(0, 9) < 3);
					default: m_tready <= seg_left[1];
				endcase
			end
		end
	end

	initial begin
		#24000000;
		$display("tb_read_range_page_splitter failed");
		$finish;
	end

	initial begin
		sb = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: error results, single byte at the end, truncation
		send_item(make_request('0, '0, '0));
		send_item(make_request(63'd100, OBJ_MAX, 32'd7));
		send_item(make_request(OBJ_MAX, OBJ_MAX - 63'd1, '1));
		send_item(make_request(OBJ_MAX, '0, '0));
		send_item(make_request(OBJ_MAX, 63'd262143, 32'd1));
		send_item(make_request(OBJ_MAX, OBJ_MAX - (63'd5 << 30), '1));
		drain();

		// smallest page, no minimum, cap of one byte
		apply_config(rrps_pkg::PAGE_LOG2_MIN, '0, 32'd1);
		send_item(make_request(63'd12288, 63'd4095, '0));
		send_item(make_request(63'd12288, 63'd4095, 32'd5));
		send_item(make_request(OBJ_MAX, OBJ_MAX - 63'd1, '1));
		drain();

		// largest page, widest lengths
		apply_config(rrps_pkg::PAGE_LOG2_MAX, '1, '1);
		send_item(make_request(OBJ_MAX, '0, '0));
		send_item(make_request((63'd10 << 19) + 63'd7, 63'd3, 32'd9));
		send_item(make_request(OBJ_MAX, OBJ_MAX - 63'd100, '0));
		drain();

		// page size clamped up; write to the unused index is dropped
		cfg_write(REG_UNUSED, 32'hDEAD_BEEF);
		apply_config('0, 32'd4097, 32'd8193);
		send_item(make_request(63'd1 << 40, 63'd5, '0));
		send_item(make_request(63'd1 << 40, (63'd1 << 40) - 63'd2, '1));
		drain();

		// page size clamped down, cap of zero
		apply_config('1, '0, '0);
		send_item(make_request(OBJ_MAX, '0, '1));
		send_item(make_request(63'd1, 63'd1, '1));
		drain();

		for (int phase = 0; phase < 6; phase++) begin
			random_config();
			if (phase == 1)
				long_hold_req = 1'b1;
			send_random(75);
			drain();
		end

		if (sb.errors == 0)
			$display("tb_read_range_page_splitter passed");
		else
			$display("tb_read_range_page_splitter failed");
		$finish;
	end

endmodule
